// File: rtl/core/mpsu_pkg.sv
// Package for the Metropolis phase site update core: word types, control structs,
// register indexes and the quarter-wave cosine tables built at elaboration.
// No dependencies.
`default_nettype none

package mpsu_pkg;

  localparam int SITES         = 1024;
  localparam int SITE_W        = $clog2(SITES);
  localparam int COS_ENTRIES   = 1024;
  localparam int COS_IDX_W     = $clog2(COS_ENTRIES);
  localparam int COS_QUARTER   = COS_ENTRIES / 4;
  localparam int COS_QTR_W     = COS_IDX_W - 2;
  localparam int WINDOW_SWEEPS = 10;

  localparam logic [23:0] STEP_RESET       = 24'd2670177;
  localparam logic [23:0] STEP_MAX         = 24'hFFFFFF;
  localparam logic [15:0] COUPLING_RESET   = 16'd256;
  localparam logic [10:0] SITE_COUNT_RESET = 11'd1024;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUPLING   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SITE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_ENABLE = 2'd2;

  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam longint unsigned PI_Q29  = 64'd1686629713;

  typedef struct packed {
    logic [9:0]         site;
    logic signed [15:0] step_random;
    logic [23:0]        accept_threshold;
  } in_word_t;

  typedef struct packed {
    logic [9:0]  site_echo;
    logic [15:0] angle_out;
    logic        accepted;
    logic        window_end;
    logic        calibrated;
    logic [23:0] step_now;
  } out_word_t;

  typedef struct packed {
    logic clear_wr;
    logic load_in;
    logic calc_ang;
    logic calc_cos;
    logic calc_mul;
    logic calc_dec;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
  } ctl_stat_t;

  typedef logic signed [16:0] cos_val_t;
  typedef cos_val_t cos_tab_t [COS_QUARTER];

  function automatic longint unsigned qw_div(input longint unsigned num, input bit want_sin,
                                             input int k);
    longint unsigned res;
    res = num;
    if (want_sin) begin
      case (k)
        0: res = num / 110;
        1: res = num / 72;
        2: res = num / 42;
        3: res = num / 20;
        default: res = num / 6;
      endcase
    end else begin
      case (k)
        0: res = num / 90;
        1: res = num / 56;
        2: res = num / 30;
        3: res = num / 12;
        default: res = num / 2;
      endcase
    end
    return res;
  endfunction

  function automatic longint qw_eval(input longint unsigned x, input bit want_sin);
    longint unsigned xr;
    longint unsigned x2;
    longint unsigned t;
    int k;
    xr = (x * PI_Q29) >> 14;
    x2 = (xr * xr) >> 30;
    t  = ONE_Q30;
    if (want_sin) begin
      for (k = 0; k < 5; k++) begin
        t = ONE_Q30 - qw_div((x2 * t) >> 30, 1'b1, k);
      end
      return longint'((xr * t) >> 30);
    end
    for (k = 0; k < 4; k++) begin
      t = ONE_Q30 - qw_div((x2 * t) >> 30, 1'b0, k);
    end
    return longint'(ONE_Q30) - longint'(qw_div((x2 * t) >> 30, 1'b0, 4));
  endfunction

  function automatic cos_val_t cos_phase(input longint unsigned p);
    longint unsigned quad;
    longint unsigned x;
    longint v;
    longint r;
    quad = (p >> 14) & 64'd3;
    x    = p & 64'd16383;
    case (quad)
      64'd0:   v = qw_eval(x, 1'b0);
      64'd1:   v = -qw_eval(x, 1'b1);
      64'd2:   v = -qw_eval(x, 1'b0);
      default: v = qw_eval(x, 1'b1);
    endcase
    r = ((v + 64'sd2147483648 + 64'sd16384) >>> 15) - 64'sd65536;
    return cos_val_t'(r);
  endfunction

  function automatic cos_tab_t cos_tab_build(input int quad);
    cos_tab_t tab;
    longint unsigned p;
    int i;
    for (i = 0; i < COS_QUARTER; i++) begin
      p = (longint'(quad * COS_QUARTER + i) * 64'd65536) / COS_ENTRIES;
      tab[i] = cos_phase(p);
    end
    return tab;
  endfunction

  localparam cos_tab_t COS_Q0 = cos_tab_build(0);
  localparam cos_tab_t COS_Q1 = cos_tab_build(1);
  localparam cos_tab_t COS_Q2 = cos_tab_build(2);
  localparam cos_tab_t COS_Q3 = cos_tab_build(3);

  function automatic cos_val_t cos_lookup(input logic [15:0] angle);
    logic [COS_IDX_W-1:0] idx;
    logic [COS_QTR_W-1:0] ofs;
    cos_val_t val;
    idx = angle[15 -: COS_IDX_W];
    ofs = idx[COS_QTR_W-1:0];
    case (idx[COS_IDX_W-1 -: 2])
      2'd0:    val = COS_Q0[ofs];
      2'd1:    val = COS_Q1[ofs];
      2'd2:    val = COS_Q2[ofs];
      default: val = COS_Q3[ofs];
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/mpsu_ctrl.sv
// Controller for the Metropolis phase site update core: clearing pass,
// per-word sequencing and output valid. Depends on mpsu_pkg.
`default_nettype none

module mpsu_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  input  mpsu_pkg::ctl_stat_t  stat_i,
  output mpsu_pkg::ctl_cmd_t   cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_ANG   = 3'd2;
  localparam logic [2:0] ST_COS   = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_DEC   = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (stat_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_ANG;
        end
      end
      ST_ANG: begin
        cmd_o.calc_ang = 1'b1;
        state_d        = ST_COS;
      end
      ST_COS: begin
        cmd_o.calc_cos = 1'b1;
        state_d        = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.calc_mul = 1'b1;
        state_d        = ST_DEC;
      end
      ST_DEC: begin
        cmd_o.calc_dec = 1'b1;
        state_d        = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("word accepted while another is in flight");

  a_finish_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> slot_free)
    else $error("result loaded over an untaken result");

  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q)
    else $error("finished result not presented");
`endif

endmodule

`default_nettype wire

// File: rtl/core/mpsu_datapath.sv
// Datapath for the Metropolis phase site update core: angle store, step product,
// cosine difference, action test, step calibration and output register. Depends on mpsu_pkg.
`default_nettype none

module mpsu_datapath (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  mpsu_pkg::ctl_cmd_t                   cmd_i,
  output mpsu_pkg::ctl_stat_t                  stat_o,
  input  mpsu_pkg::in_word_t                   in_word_i,
  output mpsu_pkg::out_word_t                  out_word_o,
  input  wire                                  cfg_we_i,
  input  wire [mpsu_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire [15:0]                           cfg_data_i
);

  logic [15:0] angles_mem [mpsu_pkg::SITES];

  logic [mpsu_pkg::SITE_W-1:0] clr_addr_q;
  logic [15:0]  coupling_q;
  logic [10:0]  site_count_q;
  logic         cal_en_q;
  logic [23:0]  step_q, step_d;
  logic [13:0]  win_cnt_q, win_cnt_d;
  logic [13:0]  acc_cnt_q, acc_cnt_d;
  logic         cal_done_q, cal_done_d;

  logic [9:0]          site_q;
  logic [23:0]         thr_q;
  logic signed [40:0]  prod_q, prod_d;
  logic [15:0]         rd_q;
  logic [15:0]         old_q, new_q;
  logic signed [17:0]  diff_q;
  logic signed [34:0]  dprod_q;
  logic                acc_q;
  logic [23:0]         step_up_q, step_dn_q;
  mpsu_pkg::out_word_t out_q;

  logic signed [40:0]     rnd_sum;
  logic [15:0]            inc;
  mpsu_pkg::cos_val_t     cos_old, cos_new;
  logic signed [17:0]     diff_d;
  logic signed [34:0]     dprod_d;
  logic signed [34:0]     ds_sum;
  logic signed [27:0]     ds;
  logic [29:0]            adj_wide;
  logic [18:0]            adj;
  logic [24:0]            up_sum;

  logic                   mem_we;
  logic [mpsu_pkg::SITE_W-1:0] mem_wa;
  logic [15:0]            mem_wd;

  logic [10:0]  sc_eff;
  logic [13:0]  total;
  logic         cal_active;
  logic [13:0]  win_inc, acc_inc;
  logic         wend;
  logic [19:0]  acc_x20, tot_x11, acc_x10, tot_x3;

  assign stat_o.clear_last = (clr_addr_q == mpsu_pkg::SITE_W'(mpsu_pkg::SITES - 1));

  assign mem_we = cmd_i.clear_wr || (cmd_i.finish && acc_q);
  assign mem_wa = cmd_i.clear_wr ? clr_addr_q : site_q[mpsu_pkg::SITE_W-1:0];
  assign mem_wd = cmd_i.clear_wr ? 16'd0 : new_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) angles_mem[mem_wa] <= mem_wd;
    if (cmd_i.load_in) rd_q <= angles_mem[in_word_i.site[mpsu_pkg::SITE_W-1:0]];
  end

  // step increment, rounded to the nearest phase unit
  assign prod_d  = $signed({1'b0, step_q}) * in_word_i.step_random;
  assign rnd_sum = prod_q + 41'sd4194304;
  assign inc     = rnd_sum[38:23];

  assign cos_old = mpsu_pkg::cos_lookup(old_q);
  assign cos_new = mpsu_pkg::cos_lookup(new_q);
  assign diff_d  = {cos_old[16], cos_old} - {cos_new[16], cos_new};

  assign dprod_d = $signed({1'b0, coupling_q}) * diff_q;
  assign ds_sum  = dprod_q + 35'sd64;
  assign ds      = ds_sum[34:7];

  assign adj_wide = {6'd0, step_q} * 30'd41 + 30'd1024;
  assign adj      = adj_wide[29:11];
  assign up_sum   = {1'b0, step_q} + {6'd0, adj};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      site_q <= in_word_i.site;
      thr_q  <= in_word_i.accept_threshold;
      prod_q <= prod_d;
    end
    if (cmd_i.calc_ang) begin
      old_q <= rd_q;
      new_q <= rd_q + inc;
    end
    if (cmd_i.calc_cos) diff_q <= diff_d;
    if (cmd_i.calc_mul) dprod_q <= dprod_d;
    if (cmd_i.calc_dec) begin
      acc_q     <= (ds <= $signed({4'd0, thr_q}));
      step_up_q <= up_sum[24] ? mpsu_pkg::STEP_MAX : up_sum[23:0];
      step_dn_q <= step_q - {5'd0, adj};
    end
    if (cmd_i.finish) out_q <= '{
      site_echo:  site_q,
      angle_out:  acc_q ? new_q : old_q,
      accepted:   acc_q,
      window_end: wend,
      calibrated: cal_done_d,
      step_now:   step_d
    };
  end

  // window length from the clamped site count
  always_comb begin
    sc_eff = site_count_q;
    if (site_count_q == 11'd0) begin
      sc_eff = 11'd1;
    end else if (site_count_q > 11'(mpsu_pkg::SITES)) begin
      sc_eff = 11'(mpsu_pkg::SITES);
    end
  end

  assign total      = 14'(mpsu_pkg::WINDOW_SWEEPS) * {3'd0, sc_eff};
  assign cal_active = cal_en_q && !cal_done_q;
  assign win_inc    = win_cnt_q + 14'd1;
  assign acc_inc    = acc_cnt_q + {13'd0, acc_q};
  assign wend       = cal_active && (win_inc >= total);
  assign acc_x20    = {6'd0, acc_inc} * 20'd20;
  assign tot_x11    = {6'd0, total} * 20'd11;
  assign acc_x10    = {6'd0, acc_inc} * 20'd10;
  assign tot_x3     = {6'd0, total} * 20'd3;

  always_comb begin
    step_d     = step_q;
    win_cnt_d  = win_cnt_q;
    acc_cnt_d  = acc_cnt_q;
    cal_done_d = cal_done_q;
    if (cal_active) begin
      win_cnt_d = win_inc;
      acc_cnt_d = acc_inc;
      if (wend) begin
        win_cnt_d = 14'd0;
        acc_cnt_d = 14'd0;
        if (acc_x20 >= tot_x11) begin
          step_d = step_up_q;
        end else if (acc_x10 <= tot_x3) begin
          step_d = step_dn_q;
        end else begin
          cal_done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q   <= '0;
      coupling_q   <= mpsu_pkg::COUPLING_RESET;
      site_count_q <= mpsu_pkg::SITE_COUNT_RESET;
      cal_en_q     <= 1'b1;
      step_q       <= mpsu_pkg::STEP_RESET;
      win_cnt_q    <= '0;
      acc_cnt_q    <= '0;
      cal_done_q   <= 1'b0;
    end else begin
      if (cmd_i.clear_wr) clr_addr_q <= clr_addr_q + 1'b1;
      if (cmd_i.finish) begin
        step_q     <= step_d;
        win_cnt_q  <= win_cnt_d;
        acc_cnt_q  <= acc_cnt_d;
        cal_done_q <= cal_done_d;
      end else if (cfg_we_i) begin
        case (cfg_index_i)
          mpsu_pkg::CFG_COUPLING:   coupling_q   <= cfg_data_i;
          mpsu_pkg::CFG_SITE_COUNT: site_count_q <= cfg_data_i[10:0];
          mpsu_pkg::CFG_CAL_ENABLE: begin
            cal_en_q <= cfg_data_i[0];
            if (cfg_data_i[0]) begin
              cal_done_q <= 1'b0;
              win_cnt_q  <= '0;
              acc_cnt_q  <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_word_o = out_q;

endmodule

`default_nettype wire

// File: rtl/core/metropolis_phase_site_update_core.sv
// Metropolis phase site update core: one proposal per input word, one result per word.
// Instantiates mpsu_ctrl and mpsu_datapath; depends on mpsu_pkg.
//
// Input words carry a site, a signed uniform step random and an exponential
// threshold; each produces one output word with the site's angle after the
// proposal, the accept bit, calibration status and the current step size.
// Both channels use valid/ready. One word is in work at a time: it is accepted
// in idle, its result is loaded into the output register after the angle, cosine,
// multiply and decide states, and the next word can be accepted on the following
// cycle. Each word runs the chain angle read, step add, cosine table pair,
// coupling multiply, action compare and commit.
// The output register frees the input side: a new word is accepted while the
// last result still waits. If the receiver stalls, the next word halts before
// its commit until the output register is taken.
// After reset the angle store is cleared, one site per cycle, through all 1024 sites;
// no word is accepted in that time. Configuration writes (enable, index, data)
// are taken except in a cycle that commits a result, and are meant for an idle block.
`default_nettype none

module metropolis_phase_site_update_core (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  mpsu_pkg::in_word_t             in_word_i,
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output mpsu_pkg::out_word_t            out_word_o,
  input  wire                            cfg_we_i,
  input  wire [mpsu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [15:0]                     cfg_data_i
);

  mpsu_pkg::ctl_cmd_t  cmd;
  mpsu_pkg::ctl_stat_t stat;

  mpsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mpsu_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_word_i   (in_word_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

`default_nettype wire
